// ===== rtl/core/implicit_list_heap_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Heap allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_MACROS_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define ILHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ILHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ilha_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heap allocator package
// Transaction types, codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package ilha_pkg;

	localparam int HEAP_UNITS_DEF = 8192;
	localparam int ALIGN_BYTES    = 8;
	localparam int HDR_BYTES      = 8;
	localparam int MAX_SPAN       = 65536;

	localparam int SIZE_W    = 17;
	localparam int OFF_W     = 16;
	localparam int WORD_W    = 16;
	localparam int POS_W     = 19;
	localparam int CFG_IDX_W = 1;

	localparam logic [2:0]        SIZE_MASK = 3'h7;
	localparam logic [WORD_W-1:0] USED_BIT  = 16'h0001;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST = 1'b1;

	typedef enum logic [1:0] {
		FUNC_ALLOC    = 2'd0,
		FUNC_FREE     = 2'd1,
		FUNC_VALIDATE = 2'd2,
		FUNC_INIT     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REJECT  = 2'd1,
		ST_NOFIT   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_SPLIT,
		WR_ALLOC,
		WR_FREE,
		WR_INIT
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_POS,
		RD_FREE
	} rd_sel_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [SIZE_W-1:0] request_bytes;
		logic [OFF_W-1:0]  block_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OFF_W-1:0] payload_offset;
	} rsp_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		logic    adv;
		wr_sel_t wr_sel;
		logic    set_res;
		status_t res_status;
		logic    res_payload;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  clr_last;
		logic  walk_done;
		logic  req_bad;
		logic  free_bad;
		logic  init_bad;
		logic  fit;
		logic  split_ok;
		logic  used;
		logic  span_bad;
	} dp_sts_t;

endpackage

// ===== rtl/core/implicit_list_heap_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Implicit list heap allocator
// First-fit allocator over a heap of 8-byte headers kept in a header RAM.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  req      | req_valid/req_stall  | func, request_bytes, block_offset
//  rsp      | rsp_valid/rsp_stall  | status, payload_offset
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  After reset a clearing pass over every header RAM word formats the RAM; no
//  transaction is taken until it ends (config writes are).
//  Free and init touch one header; allocate and validate walk the list with
//  one RAM read per header walked, as the RAM has a single read port.
//  One transaction is in work at a time; the result register lets the next
//  request be taken while a stalled result waits on rsp.
// ---------------------------------------------------------------------------
module implicit_list_heap_allocator #(
	parameter int HEAP_UNITS = ilha_pkg::HEAP_UNITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  ilha_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output ilha_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [ilha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ilha_pkg::SIZE_W-1:0]    cfg_data
);

	ilha_pkg::dp_cmd_t cmd;
	ilha_pkg::dp_sts_t sts;

	ilha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ilha_dp #(
		.HEAP_UNITS (HEAP_UNITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/ilha_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held between reads.
// ---------------------------------------------------------------------------
module ilha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/ilha_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heap allocator datapath
// Config registers, walk pointer, header RAM, header arithmetic, result regs.
// ---------------------------------------------------------------------------
`include "implicit_list_heap_allocator_macros.svh"

module ilha_dp #(
	parameter int HEAP_UNITS = ilha_pkg::HEAP_UNITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ilha_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ilha_pkg::SIZE_W-1:0]      cfg_data,
	input  ilha_pkg::req_t                   req,
	input  ilha_pkg::dp_cmd_t                cmd,
	output ilha_pkg::dp_sts_t                sts,
	output ilha_pkg::rsp_t                   rsp
);

	localparam int SW = ilha_pkg::SIZE_W;
	localparam int PW = ilha_pkg::POS_W;
	localparam int WW = ilha_pkg::WORD_W;
	localparam int AW = $clog2(HEAP_UNITS);
	localparam int FULL_BYTES = HEAP_UNITS * ilha_pkg::ALIGN_BYTES;
	localparam int CAP_BYTES  = (FULL_BYTES > ilha_pkg::MAX_SPAN) ? ilha_pkg::MAX_SPAN
		: FULL_BYTES;
	localparam logic [SW-1:0] CAP       = SW'(CAP_BYTES);
	localparam logic [SW-1:0] HDR       = SW'(ilha_pkg::HDR_BYTES);
	localparam logic [SW-1:0] MIN_SPLIT = SW'(ilha_pkg::HDR_BYTES + ilha_pkg::ALIGN_BYTES);
	localparam logic [SW-1:0] MIN_HEAP  = SW'(2 * ilha_pkg::ALIGN_BYTES);
	localparam logic [AW-1:0] LAST_UNIT = AW'(HEAP_UNITS - 1);

	logic [SW-1:0]    heap_size_q;
	logic [SW-1:0]    max_request_q;
	logic [SW-1:0]    heap_end_q;
	logic [AW-1:0]    clr_q;
	ilha_pkg::func_t  func_q;
	logic [SW-1:0]    req_q;
	logic [ilha_pkg::OFF_W-1:0] off_q;
	logic [PW-1:0]    pos_q;
	ilha_pkg::rsp_t   res_q;
	ilha_pkg::rsp_t   rsp_q;

	logic [WW-1:0] rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;

	logic [SW:0]   need_sum;
	logic [SW:0]   need;
	logic [SW-1:0] h_size;
	logic [SW-1:0] surplus;
	logic [PW-1:0] pos_next;
	logic [PW-1:0] split_pos;
	logic          split_in;
	logic [PW-1:0] free_pos;
	logic [SW-1:0] init_raw;
	logic [SW-1:0] init_end;
	logic [WW-1:0] alloc_val;

	// Header arithmetic; rounded request keeps its carry so it never wraps to a fit
	assign need_sum  = {1'b0, req_q} + (SW+1)'(ilha_pkg::ALIGN_BYTES - 1);
	assign need      = {need_sum[SW:3], 3'b000};
	assign h_size    = {1'b0, rdata[WW-1:3], 3'b000};
	assign surplus   = h_size - need[SW-1:0];
	assign pos_next  = pos_q + PW'(h_size) + PW'(HDR);
	assign split_pos = pos_q + PW'(HDR) + PW'(need);
	assign split_in  = {1'b0, split_pos[PW-1:3]} < 17'(HEAP_UNITS);
	assign free_pos  = PW'(off_q) - PW'(HDR);
	assign init_raw  = {heap_size_q[SW-1:3], 3'b000};
	assign init_end  = (init_raw > CAP) ? CAP : init_raw;
	assign alloc_val = sts.split_ok ? (need[WW-1:0] | ilha_pkg::USED_BIT)
		: ((rdata & ~WW'(ilha_pkg::SIZE_MASK)) | ilha_pkg::USED_BIT);

	always_comb begin
		sts.func      = func_q;
		sts.clr_last  = clr_q == LAST_UNIT;
		sts.walk_done = pos_q >= PW'(heap_end_q);
		sts.req_bad   = (req_q == '0) || (req_q > max_request_q);
		sts.free_bad  = (off_q == '0) || (off_q[2:0] != 3'b000)
			|| (free_pos >= PW'(heap_end_q));
		sts.init_bad  = init_end < MIN_HEAP;
		sts.used      = rdata[0];
		sts.fit       = !rdata[0] && ({1'b0, h_size} >= need);
		sts.split_ok  = surplus >= MIN_SPLIT;
		sts.span_bad  = pos_next > PW'(heap_end_q);
	end

	// RAM port steering
	always_comb begin
		ram_re    = cmd.rd_sel != ilha_pkg::RD_NONE;
		ram_raddr = (cmd.rd_sel == ilha_pkg::RD_FREE) ? free_pos[AW+2:3] : pos_q[AW+2:3];
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		case (cmd.wr_sel)
			ilha_pkg::WR_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0) ? WW'(CAP - HDR) : '0;
			end
			ilha_pkg::WR_SPLIT: begin
				ram_we    = split_in;
				ram_waddr = split_pos[AW+2:3];
				ram_wdata = WW'(surplus - HDR);
			end
			ilha_pkg::WR_ALLOC: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW+2:3];
				ram_wdata = alloc_val;
			end
			ilha_pkg::WR_FREE: begin
				ram_we    = 1'b1;
				ram_waddr = free_pos[AW+2:3];
				ram_wdata = rdata & ~ilha_pkg::USED_BIT;
			end
			ilha_pkg::WR_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = WW'(init_end - HDR);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ilha_ram #(
		.WIDTH (WW),
		.DEPTH (HEAP_UNITS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Control and configuration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q   <= SW'(ilha_pkg::MAX_SPAN);
			max_request_q <= SW'(ilha_pkg::MAX_SPAN);
			heap_end_q    <= CAP;
			clr_q         <= '0;
			pos_q         <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ilha_pkg::REG_HEAP_SIZE) begin
					heap_size_q <= cfg_data;
				end else begin
					max_request_q <= cfg_data;
				end
			end
			if (cmd.wr_sel == ilha_pkg::WR_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.wr_sel == ilha_pkg::WR_INIT) begin
				heap_end_q <= init_end;
			end
			if (cmd.load) begin
				pos_q <= '0;
			end else if (cmd.adv) begin
				pos_q <= pos_next;
			end
		end
	end

	// Transaction payload and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= ilha_pkg::func_t'(req.func);
			req_q  <= req.request_bytes;
			off_q  <= req.block_offset;
		end
		if (cmd.set_res) begin
			res_q.status         <= cmd.res_status;
			res_q.payload_offset <= cmd.res_payload ? (pos_q[15:0] + 16'(ilha_pkg::HDR_BYTES))
				: '0;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

	`ILHA_ASSERT_IMPL(a_pos_aligned, clk, arst_n, 1'b1, pos_q[2:0] == 3'b000, "walk pointer off alignment")
	`ILHA_ASSERT_IMPL(a_heap_end_sane, clk, arst_n, 1'b1, (heap_end_q[2:0] == 3'b000) && (heap_end_q >= MIN_HEAP) && (heap_end_q <= CAP), "heap end out of range")
	`ILHA_ASSERT_IMPL(a_alloc_marks_used, clk, arst_n, cmd.wr_sel == ilha_pkg::WR_ALLOC, ram_wdata[0], "allocated header without used bit")

endmodule

// ===== rtl/core/ilha_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heap allocator controller
// Sequences the clearing pass, header walks and result handover.
// ---------------------------------------------------------------------------
`include "implicit_list_heap_allocator_macros.svh"

module ilha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  ilha_pkg::dp_sts_t sts,
	output ilha_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_A_CHK,
		S_A_EVAL,
		S_A_MARK,
		S_F_EVAL,
		S_V_CHK,
		S_V_EVAL,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.rd_sel      = ilha_pkg::RD_NONE;
		cmd.wr_sel      = ilha_pkg::WR_NONE;
		cmd.res_status  = ilha_pkg::ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_sel = ilha_pkg::WR_CLEAR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.func)
					ilha_pkg::FUNC_ALLOC: begin
						if (sts.req_bad) begin
							cmd.set_res    = 1'b1;
							cmd.res_status = ilha_pkg::ST_REJECT;
							state_d        = S_RESP;
						end else begin
							state_d = S_A_CHK;
						end
					end
					ilha_pkg::FUNC_FREE: begin
						if (sts.free_bad) begin
							cmd.set_res    = 1'b1;
							cmd.res_status = ilha_pkg::ST_REJECT;
							state_d        = S_RESP;
						end else begin
							cmd.rd_sel = ilha_pkg::RD_FREE;
							state_d    = S_F_EVAL;
						end
					end
					ilha_pkg::FUNC_VALIDATE: begin
						state_d = S_V_CHK;
					end
					default: begin
						cmd.set_res = 1'b1;
						if (sts.init_bad) begin
							cmd.res_status = ilha_pkg::ST_INVALID;
						end else begin
							cmd.wr_sel = ilha_pkg::WR_INIT;
						end
						state_d = S_RESP;
					end
				endcase
			end
			S_A_CHK: begin
				if (sts.walk_done) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ilha_pkg::ST_NOFIT;
					state_d        = S_RESP;
				end else begin
					cmd.rd_sel = ilha_pkg::RD_POS;
					state_d    = S_A_EVAL;
				end
			end
			S_A_EVAL: begin
				if (!sts.fit) begin
					cmd.adv = 1'b1;
					state_d = S_A_CHK;
				end else if (sts.split_ok) begin
					cmd.wr_sel = ilha_pkg::WR_SPLIT;
					state_d    = S_A_MARK;
				end else begin
					cmd.wr_sel      = ilha_pkg::WR_ALLOC;
					cmd.set_res     = 1'b1;
					cmd.res_payload = 1'b1;
					state_d         = S_RESP;
				end
			end
			S_A_MARK: begin
				// read data still holds the block header, so split_ok is unchanged
				cmd.wr_sel      = ilha_pkg::WR_ALLOC;
				cmd.set_res     = 1'b1;
				cmd.res_payload = 1'b1;
				state_d         = S_RESP;
			end
			S_F_EVAL: begin
				cmd.set_res = 1'b1;
				if (sts.used) begin
					cmd.wr_sel = ilha_pkg::WR_FREE;
				end else begin
					cmd.res_status = ilha_pkg::ST_REJECT;
				end
				state_d = S_RESP;
			end
			S_V_CHK: begin
				// overrun is caught per header, so reaching the end means exact tiling
				if (sts.walk_done) begin
					cmd.set_res = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_sel = ilha_pkg::RD_POS;
					state_d    = S_V_EVAL;
				end
			end
			S_V_EVAL: begin
				if (sts.span_bad) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ilha_pkg::ST_INVALID;
					state_d        = S_RESP;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_V_CHK;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	`ILHA_ASSERT_NEXT(a_res_to_resp, clk, arst_n, cmd.set_res, state_q == S_RESP, "result set outside completion path")
	`ILHA_ASSERT_IMPL(a_clear_quiet, clk, arst_n, state_q == S_CLEAR, !cmd.load && !cmd.out_load && (cmd.rd_sel == ilha_pkg::RD_NONE), "activity during clearing pass")
	`ILHA_ASSERT_NEXT(a_out_kept, clk, arst_n, rsp_valid_q && rsp_stall, rsp_valid_q, "pending result dropped")

endmodule

// ===== verif/tb_implicit_list_heap_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heap allocator testbench
// Drives allocate, free, validate and init transactions against a model of
// the header list kept in the bench, and checks every result in order.
// Directed cases cover rejection, no fit, split rules, double free, frees
// off the list and init sizes. Random phases then run well-formed
// allocate/free traffic mixed with noise over a range of heap settings.
// ---------------------------------------------------------------------------
module tb_implicit_list_heap_allocator;

	import ilha_pkg::*;

	localparam int          HEAP_UNITS  = HEAP_UNITS_DEF;
	localparam int unsigned HEAP_CAP    = (HEAP_UNITS * ALIGN_BYTES > MAX_SPAN) ?
	                                      MAX_SPAN : HEAP_UNITS * ALIGN_BYTES;
	localparam logic [31:0] SIZE_CLR    = ~{29'b0, SIZE_MASK};
	localparam int          STALL_LIMIT = 100000;
	localparam int          TAIL_CYCLES = 32;
	localparam int          RAND_PHASES = 12;
	localparam int          PHASE_OPS   = 136;
	localparam int          QUIET_PHASE = 5;
	localparam int unsigned OFF_MAX     = 65535;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HEAP_SIZE;
	logic [SIZE_W-1:0] cfg_data = '0;

	// bench copy of the allocator state
	logic [WORD_W-1:0] hdr_mem [HEAP_UNITS];
	int unsigned       heap_end_b;
	int unsigned       cfg_heap_size;
	int unsigned       cfg_max_request;

	rsp_t        heap_outcomes_q [$];
	rsp_t        last_outcome;
	int unsigned live_blocks [$];
	int unsigned freed_blocks [$];
	logic        no_idle = 1'b0;
	int          fail_count = 0;
	int          idle_cycles = 0;

	implicit_list_heap_allocator #(
		.HEAP_UNITS(HEAP_UNITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rsp_t apply_heap_op(req_t item);
		rsp_t              res;
		int unsigned       need, pos, sz, span, fmt_end, off;
		logic [WORD_W-1:0] word;
		logic              done;
		res.status = ST_OK;
		res.payload_offset = '0;
		done = 1'b0;
		pos = 0;
		case (item.func)
		FUNC_ALLOC: begin
			if (item.request_bytes == 0 || item.request_bytes > cfg_max_request) begin
				res.status = ST_REJECT;
			end else begin
				need = (item.request_bytes + ALIGN_BYTES - 1) & SIZE_CLR;
				res.status = ST_NOFIT;
				while (pos < heap_end_b && !done) begin
					word = hdr_mem[pos / ALIGN_BYTES];
					sz = word & SIZE_CLR;
					if ((word & USED_BIT) == 0 && sz >= need) begin
						// split only if the tail can hold a header and one unit
						if (sz - need >= HDR_BYTES + ALIGN_BYTES) begin
							hdr_mem[(pos + HDR_BYTES + need) / ALIGN_BYTES] =
								WORD_W'(sz - need - HDR_BYTES);
							sz = need;
						end
						hdr_mem[pos / ALIGN_BYTES] = WORD_W'(sz | USED_BIT);
						res.payload_offset = OFF_W'(pos + HDR_BYTES);
						res.status = ST_OK;
						done = 1'b1;
					end else begin
						pos = pos + HDR_BYTES + sz;
					end
				end
			end
		end
		FUNC_FREE: begin
			off = item.block_offset;
			if (off == 0 || (off & SIZE_MASK) != 0 || off - HDR_BYTES >= heap_end_b) begin
				res.status = ST_REJECT;
			end else begin
				// no list check: whatever word sits below the offset is used
				word = hdr_mem[(off - HDR_BYTES) / ALIGN_BYTES];
				if ((word & USED_BIT) == 0)
					res.status = ST_REJECT;
				else
					hdr_mem[(off - HDR_BYTES) / ALIGN_BYTES] = word & ~USED_BIT;
			end
		end
		FUNC_VALIDATE: begin
			while (pos < heap_end_b && !done) begin
				span = (hdr_mem[pos / ALIGN_BYTES] & SIZE_CLR) + HDR_BYTES;
				if (span > heap_end_b - pos)
					done = 1'b1;
				else
					pos = pos + span;
			end
			if (done || pos != heap_end_b)
				res.status = ST_INVALID;
		end
		default: begin
			fmt_end = cfg_heap_size & SIZE_CLR;
			if (fmt_end > HEAP_CAP)
				fmt_end = HEAP_CAP;
			if (fmt_end < 2 * ALIGN_BYTES) begin
				res.status = ST_INVALID;
			end else begin
				heap_end_b = fmt_end;
				hdr_mem[0] = WORD_W'(fmt_end - HDR_BYTES);
			end
		end
		endcase
		return res;
	endfunction

	task automatic issue_op(input func_t f, input int unsigned nbytes, input int unsigned off);
		req_t item;
		item.func = f;
		item.request_bytes = SIZE_W'(nbytes);
		item.block_offset = OFF_W'(off);
		if (!no_idle && $urandom_range(99) < 10) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		last_outcome = apply_heap_op(item);
		heap_outcomes_q.push_back(last_outcome);
	endtask

	task automatic wait_heap_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (heap_outcomes_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_regs(input int unsigned heap_bytes, input int unsigned req_limit);
		wait_heap_idle();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_HEAP_SIZE;
		cfg_data <= heap_bytes[SIZE_W-1:0];
		@(posedge clk);
		cfg_index <= REG_MAX_REQUEST;
		cfg_data <= req_limit[SIZE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_heap_size = heap_bytes & 32'h1FFFF;
		cfg_max_request = req_limit & 32'h1FFFF;
	endtask

	task automatic test_reset_heap();
		issue_op(FUNC_VALIDATE, 0, 0);
		issue_op(FUNC_ALLOC, 1, 0);
		issue_op(FUNC_ALLOC, MAX_SPAN, 0);
		issue_op(FUNC_ALLOC, 0, 0);
	endtask

	task automatic test_free_rules();
		issue_op(FUNC_FREE, 0, 0);
		issue_op(FUNC_FREE, 0, 12);
		issue_op(FUNC_FREE, 0, 8);
		issue_op(FUNC_FREE, 0, 8);
		issue_op(FUNC_FREE, MAX_SPAN, OFF_MAX);
	endtask

	task automatic test_init_sizes();
		set_regs(0, MAX_SPAN);
		issue_op(FUNC_INIT, 0, 0);
		set_regs(15, MAX_SPAN);
		issue_op(FUNC_INIT, 0, 0);
		set_regs(16, MAX_SPAN);
		issue_op(FUNC_INIT, 0, 0);
		issue_op(FUNC_ALLOC, 8, 0);
		issue_op(FUNC_ALLOC, 1, 0);
		issue_op(FUNC_VALIDATE, 0, 0);
	endtask

	task automatic test_split_rules();
		set_regs(40, MAX_SPAN);
		issue_op(FUNC_INIT, 0, 0);
		issue_op(FUNC_ALLOC, 9, 0);
		issue_op(FUNC_FREE, 0, 48);
		// tail of 8 bytes is too short to split off
		set_regs(32, MAX_SPAN);
		issue_op(FUNC_INIT, 0, 0);
		issue_op(FUNC_ALLOC, 16, 0);
	endtask

	task automatic test_stale_header_free();
		set_regs(64, MAX_SPAN);
		issue_op(FUNC_INIT, 0, 0);
		issue_op(FUNC_ALLOC, 8, 0);
		issue_op(FUNC_ALLOC, 8, 0);
		// reformat leaves the old used header at offset 16 inside the payload
		issue_op(FUNC_INIT, 0, 0);
		issue_op(FUNC_FREE, 0, 24);
	endtask

	task automatic test_request_limit();
		set_regs(64, 1);
		issue_op(FUNC_ALLOC, 2, 0);
		issue_op(FUNC_ALLOC, 1, 0);
	endtask

	task automatic test_random_traffic();
		int unsigned n_heap, n_max, nbytes, off, lim, sel;
		int          idx;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(9))
			0: n_heap = MAX_SPAN;
			1: n_heap = $urandom_range(0, 15);
			default: n_heap = $urandom_range(16, 2047);
			endcase
			case ($urandom_range(7))
			0: n_max = 1;
			1: n_max = MAX_SPAN;
			default: n_max = $urandom_range(8, 1024);
			endcase
			if (ph == 0)
				n_heap = MAX_SPAN;
			set_regs(n_heap, n_max);
			no_idle = (ph == QUIET_PHASE);
			issue_op(FUNC_INIT, $urandom_range(0, MAX_SPAN), $urandom_range(0, OFF_MAX));
			if (last_outcome.status == ST_OK) begin
				live_blocks.delete();
				freed_blocks.delete();
			end
			for (int k = 0; k < PHASE_OPS; k++) begin
				sel = $urandom_range(99);
				if (sel < 45) begin
					case ($urandom_range(19))
					0: lim = cfg_max_request;
					1, 2, 3, 4: lim = heap_end_b / 4;
					default: lim = 64;
					endcase
					if (lim > cfg_max_request)
						lim = cfg_max_request;
					issue_op(FUNC_ALLOC, $urandom_range(1, lim), $urandom_range(0, OFF_MAX));
					if (last_outcome.status == ST_OK)
						live_blocks.push_back(last_outcome.payload_offset);
				end else if (sel < 50) begin
					if (cfg_max_request < MAX_SPAN && $urandom_range(1) == 1)
						nbytes = $urandom_range(cfg_max_request + 1, MAX_SPAN);
					else
						nbytes = 0;
					issue_op(FUNC_ALLOC, nbytes, $urandom_range(0, OFF_MAX));
				end else if (sel < 78 && live_blocks.size() != 0) begin
					idx = $urandom_range(0, live_blocks.size() - 1);
					off = live_blocks[idx];
					live_blocks.delete(idx);
					issue_op(FUNC_FREE, $urandom_range(0, MAX_SPAN), off);
					if (freed_blocks.size() == 16)
						void'(freed_blocks.pop_front());
					freed_blocks.push_back(off);
				end else if (sel < 86) begin
					case ($urandom_range(4))
					0: off = 0;
					1: off = ($urandom_range(0, OFF_MAX) & SIZE_CLR) | $urandom_range(1, 7);
					2: off = $urandom_range(0, OFF_MAX);
					3: off = (freed_blocks.size() != 0) ?
					         freed_blocks[$urandom_range(0, freed_blocks.size() - 1)] : 0;
					default: off = $urandom_range(1, heap_end_b / ALIGN_BYTES - 1) * ALIGN_BYTES;
					endcase
					issue_op(FUNC_FREE, $urandom_range(0, MAX_SPAN), off);
				end else if (sel < 96) begin
					issue_op(FUNC_VALIDATE, $urandom_range(0, MAX_SPAN), $urandom_range(0, OFF_MAX));
				end else begin
					issue_op(FUNC_INIT, $urandom_range(0, MAX_SPAN), $urandom_range(0, OFF_MAX));
					if (last_outcome.status == ST_OK) begin
						live_blocks.delete();
						freed_blocks.delete();
					end
				end
			end
		end
		no_idle = 1'b0;
		set_regs(MAX_SPAN, MAX_SPAN);
		issue_op(FUNC_INIT, 0, 0);
		issue_op(FUNC_VALIDATE, 0, 0);
	endtask

	always @(posedge clk)
		rsp_stall <= !no_idle && ($urandom_range(99) < 10);

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (heap_outcomes_q.size() == 0) begin
				$error("result with nothing pending: status %0d, payload_offset %0d",
				       rsp.status, rsp.payload_offset);
				fail_count++;
			end else begin
				want = heap_outcomes_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.payload_offset !== want.payload_offset) begin
					$error("payload_offset: expected %0d, actual %0d",
					       want.payload_offset, rsp.payload_offset);
					fail_count++;
				end
			end
		end
	end

	// covers the clearing pass after reset and the longest header walk
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$error("no transaction for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < HEAP_UNITS; i++)
			hdr_mem[i] = '0;
		heap_end_b = HEAP_CAP;
		hdr_mem[0] = WORD_W'(HEAP_CAP - HDR_BYTES);
		cfg_heap_size = MAX_SPAN;
		cfg_max_request = MAX_SPAN;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_heap();
		test_free_rules();
		test_init_sizes();
		test_split_rules();
		test_stale_header_free();
		test_request_limit();
		test_random_traffic();

		wait_heap_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ilha_pkg.sv
rtl/core/ilha_ram.sv
rtl/core/ilha_dp.sv
rtl/core/ilha_ctrl.sv
rtl/core/implicit_list_heap_allocator.sv
verif/tb_implicit_list_heap_allocator.sv
